### sv/pbs_pkg.sv
// ----------------------------------------------------------------------------
// Particle box step package
// Shared types, codes, constants and saturation helpers for the particle box.
// ----------------------------------------------------------------------------
package pbs_pkg;

  // Default table depth.
  localparam int MAX_PARTICLES_DEF = 64;

  // Field widths.
  localparam int ID_W  = 16;
  localparam int VAL_W = 32;
  localparam int RAD_W = 31;
  localparam int DV_W  = 20;

  // Command codes.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_STEP   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SIDE   = 2'd2;
  localparam logic [1:0] REG_ENERGY = 2'd3;

  // Register reset values.
  localparam logic [30:0] WIDTH_RST  = 31'd52428800;
  localparam logic [30:0] HEIGHT_RST = 31'd39321600;
  localparam logic [16:0] ENERGY_RST = 17'd65536;

  // Push strength, 5.0 in Q16.16.
  localparam logic [18:0] PUSH_Q = 19'd327680;

  // Particle phase.
  typedef enum logic [1:0] {
    PH_IN  = 2'd0,
    PH_JL  = 2'd1,
    PH_OUT = 2'd2
  } phase_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] vx;
    logic signed [VAL_W-1:0] vy;
    logic [RAD_W-1:0]        r;
    phase_t                  ph;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result beat without the last flag.
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] vx;
    logic signed [VAL_W-1:0] vy;
    logic [RAD_W-1:0]        r;
    logic                    jl;
    logic                    ho;
  } result_t;

  // Request to the pair push unit.
  typedef struct packed {
    logic signed [VAL_W-1:0] xi;
    logic signed [VAL_W-1:0] yi;
    logic [RAD_W-1:0]        ri;
    logic signed [VAL_W-1:0] xj;
    logic signed [VAL_W-1:0] yj;
    logic [RAD_W-1:0]        rj;
  } pair_req_t;

  // Response of the pair push unit.
  typedef struct packed {
    logic                   done;
    logic                   hit;
    logic signed [DV_W-1:0] dvx;
    logic signed [DV_W-1:0] dvy;
  } pair_rsp_t;

  localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

  // Clamp a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > S32_MAX) begin
      res = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Negate with the most negative value mapping to the most positive.
  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] res;
    if (v == 32'sh80000000) begin
      res = 32'sh7fffffff;
    end else begin
      res = -v;
    end
    return res;
  endfunction

endpackage

### sv/pbs_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one insert, remove or step command per beat.
// ----------------------------------------------------------------------------
interface pbs_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        particle_id;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [30:0]        disc_radius;

  modport source (
    output valid, action, particle_id, pos_x, pos_y, vel_x, vel_y, disc_radius,
    input  ready
  );
  modport sink (
    input  valid, action, particle_id, pos_x, pos_y, vel_x, vel_y, disc_radius,
    output ready
  );
endinterface

### sv/pbs_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one updated particle per beat.
// ----------------------------------------------------------------------------
interface pbs_res_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_id;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic [30:0]        out_radius;
  logic               just_left;
  logic               handover;
  logic               last_result;

  modport source (
    output valid, out_id, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_radius,
           just_left, handover, last_result,
    input  ready
  );
  modport sink (
    input  valid, out_id, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_radius,
           just_left, handover, last_result,
    output ready
  );
endinterface

### sv/pbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/pbs_pair.sv
// ----------------------------------------------------------------------------
// Pair push unit
// Tests one particle pair for overlap and computes 5.0 * unit(d) over cycles.
// ----------------------------------------------------------------------------
module pbs_pair (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pbs_pkg::pair_req_t req,
  output pbs_pkg::pair_rsp_t rsp
);

  typedef enum logic [10:0] {
    P_IDLE = 11'h001,
    P_CHK  = 11'h002,
    P_MRS  = 11'h004,
    P_MDX  = 11'h008,
    P_MDY  = 11'h010,
    P_CMP  = 11'h020,
    P_SQRT = 11'h040,
    P_LEN  = 11'h080,
    P_MQX  = 11'h100,
    P_MQY  = 11'h200,
    P_DIV  = 11'h400
  } pstate_t;

  pstate_t            state;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [31:0]        rs;
  logic [31:0]        adx;
  logic [31:0]        ady;
  logic               sx;
  logic               sy;
  logic [63:0]        rs2;
  logic [63:0]        dx2;
  logic [63:0]        dy2;
  logic [63:0]        sq_n;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [51:0]        remx;
  logic [51:0]        remy;
  logic [51:0]        dsh;
  logic [17:0]        qx;
  logic [17:0]        qy;
  logic [4:0]         cnt;

  logic [32:0]        dx_abs;
  logic [32:0]        dy_abs;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        sq_t;
  logic               gex;
  logic               gey;

  // Magnitudes of the distance components.
  assign dx_abs = dx[32] ? 33'(-dx) : 33'(dx);
  assign dy_abs = dy[32] ? 33'(-dy) : 33'(dy);

  // The one shared multiplier and its operand selection.
  always_comb begin
    case (state)
      P_MRS: begin
        mul_a = rs;
        mul_b = rs;
      end
      P_MDX: begin
        mul_a = adx;
        mul_b = adx;
      end
      P_MDY: begin
        mul_a = ady;
        mul_b = ady;
      end
      P_MQX: begin
        mul_a = adx;
        mul_b = 32'(pbs_pkg::PUSH_Q);
      end
      default: begin
        mul_a = ady;
        mul_b = 32'(pbs_pkg::PUSH_Q);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // One root step and one quotient bit per cycle.
  assign sq_t = sq_res + sq_bit;
  assign gex  = remx >= dsh;
  assign gey  = remy >= dsh;

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= P_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        P_IDLE: begin
          if (start) begin
            dx    <= 33'(req.xi) - 33'(req.xj);
            dy    <= 33'(req.yi) - 33'(req.yj);
            rs    <= 32'(req.ri) + 32'(req.rj);
            state <= P_CHK;
          end
        end
        P_CHK: begin
          adx <= dx_abs[31:0];
          ady <= dy_abs[31:0];
          sx  <= dx[32];
          sy  <= dy[32];
          if (dx_abs > {1'b0, rs} || dy_abs > {1'b0, rs}) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            state    <= P_IDLE;
          end else begin
            state <= P_MRS;
          end
        end
        P_MRS: begin
          rs2   <= mul_p;
          state <= P_MDX;
        end
        P_MDX: begin
          dx2   <= mul_p;
          state <= P_MDY;
        end
        P_MDY: begin
          dy2   <= mul_p;
          state <= P_CMP;
        end
        P_CMP: begin
          sq_n   <= dx2 + dy2;
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          if (dy2 > rs2 || dx2 > rs2 - dy2) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            state    <= P_IDLE;
          end else begin
            state <= P_SQRT;
          end
        end
        P_SQRT: begin
          if (sq_n >= sq_t) begin
            sq_n   <= sq_n - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= P_LEN;
          end
        end
        P_LEN: begin
          // A coincident pair gives no push.
          if (sq_res == '0) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            state    <= P_IDLE;
          end else begin
            state <= P_MQX;
          end
        end
        P_MQX: begin
          remx  <= mul_p[51:0];
          state <= P_MQY;
        end
        P_MQY: begin
          remy  <= mul_p[51:0];
          dsh   <= 52'(sq_res[31:0]) << 18;
          cnt   <= 5'd18;
          state <= P_DIV;
        end
        P_DIV: begin
          if (gex) begin
            remx <= remx - dsh;
          end
          if (gey) begin
            remy <= remy - dsh;
          end
          qx  <= {qx[16:0], gex};
          qy  <= {qy[16:0], gey};
          dsh <= dsh >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b1;
            rsp.dvx  <= sx ? -$signed({1'b0, qx, gex}) : $signed({1'b0, qx, gex});
            rsp.dvy  <= sy ? -$signed({1'b0, qy, gey}) : $signed({1'b0, qy, gey});
            state    <= P_IDLE;
          end
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/particle_box_step.sv
// ----------------------------------------------------------------------------
// Particle box step
// Table of disc particles with insert, remove and a full collision step.
// ----------------------------------------------------------------------------
// The table lives in two banks of one RAM entry per particle; a step or a
// remove reads the current bank and writes the other one, then swaps them.
// A step visits every ordered pair through the one registered read port;
// the pair unit resolves each overlapping pair with an iterative root (one
// step a cycle) and an iterative divide (one quotient bit a cycle). Results
// of a step leave in table order; the block takes no new command until the
// last result of a step has been handed to the output register.
module particle_box_step #(
  parameter int MAX_PARTICLES = pbs_pkg::MAX_PARTICLES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  pbs_cmd_if.sink          cmd,
  pbs_res_if.source        res,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [30:0]      cfg_data
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_PARTICLES);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_CP_RD = 18'h00002,
    S_CP_WR = 18'h00004,
    S_I_RD = 18'h00008,
    S_I_LD = 18'h00010,
    S_J_RD = 18'h00020,
    S_J_GO = 18'h00040,
    S_J_WT = 18'h00080,
    S_SAT = 18'h00100,
    S_PH = 18'h00200,
    S_XL = 18'h00400,
    S_YT = 18'h00800,
    S_YB = 18'h01000,
    S_MV = 18'h02000,
    S_SCX = 18'h04000,
    S_SCY = 18'h08000,
    S_EMIT = 18'h10000,
    S_FIN = 18'h20000
  } state_t;

  // Control registers.
  state_t           state;
  logic             bank;
  logic [CW-1:0]    count;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    k;
  logic [CW-1:0]    wk;
  logic [CW-1:0]    kept;
  logic             found;
  logic             hold_valid;
  logic             out_valid;

  // Configuration.
  logic [30:0]      cw;
  logic [30:0]      ch;
  logic             side;
  logic [16:0]      ef;

  // Datapath registers.
  logic [15:0]              pid;
  pbs_pkg::entry_t          cur;
  logic signed [39:0]       acc_vx;
  logic signed [39:0]       acc_vy;
  logic signed [33:0]       x;
  logic signed [33:0]       y;
  logic signed [31:0]       vx;
  logic signed [31:0]       vy;
  pbs_pkg::phase_t          ph;
  logic                     changed;
  logic                     ho;
  pbs_pkg::result_t         hold;
  pbs_pkg::result_t         outr;
  logic                     out_last;

  // Memory ports.
  logic [AW-1:0]            raddr;
  logic [pbs_pkg::ENTRY_W-1:0] rdata [2];
  logic [1:0]               bank_we;
  pbs_pkg::entry_t          rd_e;
  logic                     wr_en;
  logic                     wr_cur;
  logic [AW-1:0]            wr_addr;
  pbs_pkg::entry_t          wr_data;

  // Pair unit.
  logic                     pair_start;
  pbs_pkg::pair_req_t       pair_req;
  pbs_pkg::pair_rsp_t       pair_rsp;

  // Step arithmetic.
  logic                     fire;
  logic                     out_free;
  logic                     emit_go;
  logic signed [33:0]       rr;
  logic signed [33:0]       wr_lim;
  logic signed [33:0]       hr_lim;
  logic                     in_box;
  pbs_pkg::phase_t          ph_new;
  logic                     chg_new;
  logic signed [31:0]       sc_v;
  logic signed [49:0]       sc_p;
  logic signed [49:0]       sc_q;
  logic signed [31:0]       sc_res;
  pbs_pkg::result_t         new_res;

  assign fire      = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !out_valid || res.ready;
  assign emit_go   = (state == S_EMIT) && (!hold_valid || out_free);
  assign rd_e      = pbs_pkg::entry_t'(rdata[bank]);

  // Two table banks.
  for (genvar b = 0; b < 2; b++) begin : g_bank
    assign bank_we[b] = wr_en && ((b[0] == bank) == wr_cur);
    pbs_ram #(
      .WIDTH(pbs_pkg::ENTRY_W),
      .DEPTH(MAX_PARTICLES)
    ) u_ram (
      .clk  (clk),
      .we   (bank_we[b]),
      .waddr(wr_addr),
      .wdata(wr_data),
      .raddr(raddr),
      .rdata(rdata[b])
    );
  end

  // Read address selection.
  always_comb begin
    case (state)
      S_CP_RD: raddr = k[AW-1:0];
      S_J_RD:  raddr = j[AW-1:0];
      default: raddr = i[AW-1:0];
    endcase
  end

  // Step result of the particle in hand.
  always_comb begin
    new_res.id = cur.id;
    new_res.x  = x[31:0];
    new_res.y  = y[31:0];
    new_res.vx = vx;
    new_res.vy = vy;
    new_res.r  = cur.r;
    new_res.jl = (ph == pbs_pkg::PH_JL);
    new_res.ho = ho;
  end

  // Write port selection: insert into the current bank, remove copies and step results to the other.
  always_comb begin
    wr_en   = 1'b0;
    wr_cur  = 1'b0;
    wr_addr = kept[AW-1:0];
    wr_data = rd_e;
    case (state)
      S_IDLE: begin
        wr_en      = fire && cmd.action == pbs_pkg::ACT_INSERT && count < CMAX;
        wr_cur     = 1'b1;
        wr_addr    = count[AW-1:0];
        wr_data.id = cmd.particle_id;
        wr_data.x  = cmd.pos_x;
        wr_data.y  = cmd.pos_y;
        wr_data.vx = cmd.vel_x;
        wr_data.vy = cmd.vel_y;
        wr_data.r  = cmd.disc_radius;
        wr_data.ph = pbs_pkg::PH_IN;
      end
      S_CP_WR: begin
        wr_en   = found || rd_e.id != pid;
        wr_addr = wk[AW-1:0];
      end
      S_EMIT: begin
        wr_en      = emit_go;
        wr_data.id = cur.id;
        wr_data.x  = x[31:0];
        wr_data.y  = y[31:0];
        wr_data.vx = vx;
        wr_data.vy = vy;
        wr_data.r  = cur.r;
        wr_data.ph = ph;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Pair unit hookup.
  assign pair_start  = (state == S_J_GO) && rd_e.id != cur.id;
  assign pair_req.xi = cur.x;
  assign pair_req.yi = cur.y;
  assign pair_req.ri = cur.r;
  assign pair_req.xj = rd_e.x;
  assign pair_req.yj = rd_e.y;
  assign pair_req.rj = rd_e.r;

  pbs_pair u_pair (
    .clk  (clk),
    .rst  (rst),
    .start(pair_start),
    .req  (pair_req),
    .rsp  (pair_rsp)
  );

  // Wall limits and phase decision.
  assign rr      = 34'(cur.r);
  assign wr_lim  = 34'(cw) - rr;
  assign hr_lim  = 34'(ch) - rr;
  assign in_box  = side ? (x >= rr) : (x <= wr_lim);
  assign ph_new  = in_box ? pbs_pkg::PH_IN :
                   (cur.ph == pbs_pkg::PH_IN) ? pbs_pkg::PH_JL : pbs_pkg::PH_OUT;
  assign chg_new = (ph_new != cur.ph);

  // Energy scaling, truncated toward zero.
  assign sc_v   = (state == S_SCX) ? vx : vy;
  assign sc_p   = sc_v * $signed({1'b0, ef});
  assign sc_q   = (sc_p + (sc_p[49] ? 50'sd65535 : 50'sd0)) >>> 16;
  assign sc_res = pbs_pkg::sat32(40'(sc_q));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cw   <= pbs_pkg::WIDTH_RST;
      ch   <= pbs_pkg::HEIGHT_RST;
      side <= 1'b0;
      ef   <= pbs_pkg::ENERGY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pbs_pkg::REG_WIDTH:  cw   <= cfg_data;
        pbs_pkg::REG_HEIGHT: ch   <= cfg_data;
        pbs_pkg::REG_SIDE:   side <= cfg_data[0];
        pbs_pkg::REG_ENERGY: ef   <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bank       <= 1'b0;
      count      <= '0;
      i          <= '0;
      j          <= '0;
      k          <= '0;
      wk         <= '0;
      kept       <= '0;
      found      <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fire) begin
            case (cmd.action)
              pbs_pkg::ACT_INSERT: begin
                if (count < CMAX) begin
                  count <= count + CW'(1);
                end
              end
              pbs_pkg::ACT_REMOVE: begin
                k     <= '0;
                wk    <= '0;
                found <= 1'b0;
                state <= S_CP_RD;
              end
              pbs_pkg::ACT_STEP: begin
                i     <= '0;
                kept  <= '0;
                state <= S_I_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_CP_RD: begin
          if (k == count) begin
            count <= count - CW'(found);
            bank  <= ~bank;
            state <= S_IDLE;
          end else begin
            state <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          if (!found && rd_e.id == pid) begin
            found <= 1'b1;
          end else begin
            wk <= wk + CW'(1);
          end
          k     <= k + CW'(1);
          state <= S_CP_RD;
        end
        S_I_RD: begin
          state <= (i == count) ? S_FIN : S_I_LD;
        end
        S_I_LD: begin
          j     <= '0;
          state <= S_J_RD;
        end
        S_J_RD: begin
          state <= (j == count) ? S_SAT : S_J_GO;
        end
        S_J_GO: begin
          if (pair_start) begin
            state <= S_J_WT;
          end else begin
            j     <= j + CW'(1);
            state <= S_J_RD;
          end
        end
        S_J_WT: begin
          if (pair_rsp.done) begin
            j     <= j + CW'(1);
            state <= S_J_RD;
          end
        end
        S_SAT: state <= S_PH;
        S_PH:  state <= S_XL;
        S_XL:  state <= S_YT;
        S_YT:  state <= S_YB;
        S_YB:  state <= S_MV;
        S_MV: begin
          if (ph == pbs_pkg::PH_OUT) begin
            i     <= i + CW'(1);
            state <= S_I_RD;
          end else begin
            state <= S_SCX;
          end
        end
        S_SCX: state <= S_SCY;
        S_SCY: state <= S_EMIT;
        S_EMIT: begin
          if (emit_go) begin
            if (hold_valid) begin
              out_valid <= 1'b1;
            end
            hold_valid <= 1'b1;
            kept       <= kept + CW'(1);
            i          <= i + CW'(1);
            state      <= S_I_RD;
          end
        end
        S_FIN: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              out_valid <= 1'b1;
            end
            hold_valid <= 1'b0;
            count      <= kept;
            bank       <= ~bank;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Particle datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pid <= cmd.particle_id;
      end
      S_I_LD: begin
        cur    <= rd_e;
        acc_vx <= 40'(rd_e.vx);
        acc_vy <= 40'(rd_e.vy);
      end
      S_J_WT: begin
        if (pair_rsp.done && pair_rsp.hit) begin
          acc_vx <= acc_vx + 40'(pair_rsp.dvx);
          acc_vy <= acc_vy + 40'(pair_rsp.dvy);
        end
      end
      S_SAT: begin
        vx <= pbs_pkg::sat32(acc_vx);
        vy <= pbs_pkg::sat32(acc_vy);
        x  <= 34'(cur.x);
        y  <= 34'(cur.y);
      end
      S_PH: begin
        // Phase update and the right wall.
        ph      <= ph_new;
        changed <= chg_new;
        ho      <= 1'b0;
        if (x > wr_lim) begin
          if (side) begin
            vx <= pbs_pkg::neg_sat(vx);
            x  <= wr_lim;
          end
          ho <= chg_new && ph_new == pbs_pkg::PH_JL && !side;
        end
      end
      S_XL: begin
        if (x < rr) begin
          if (!side) begin
            vx <= pbs_pkg::neg_sat(vx);
            x  <= rr;
          end
          if (changed && ph == pbs_pkg::PH_JL && side) begin
            ho <= 1'b1;
          end
        end
      end
      S_YT: begin
        if (y > hr_lim) begin
          vy <= pbs_pkg::neg_sat(vy);
          y  <= hr_lim;
        end
      end
      S_YB: begin
        if (y < rr) begin
          vy <= pbs_pkg::neg_sat(vy);
          y  <= rr;
        end
      end
      S_MV: begin
        x <= 34'(pbs_pkg::sat32(40'(x) + 40'(vx)));
        y <= 34'(pbs_pkg::sat32(40'(y) + 40'(vy)));
      end
      S_SCX: begin
        vx <= sc_res;
      end
      S_SCY: begin
        vy <= sc_res;
      end
      S_EMIT: begin
        // The held result moves out; the newest one waits for its last flag.
        if (emit_go) begin
          if (hold_valid) begin
            outr     <= hold;
            out_last <= 1'b0;
          end
          hold <= new_res;
        end
      end
      S_FIN: begin
        if (hold_valid && out_free) begin
          outr     <= hold;
          out_last <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result port.
  assign res.valid       = out_valid;
  assign res.out_id      = outr.id;
  assign res.out_pos_x   = outr.x;
  assign res.out_pos_y   = outr.y;
  assign res.out_vel_x   = outr.vx;
  assign res.out_vel_y   = outr.vy;
  assign res.out_radius  = outr.r;
  assign res.just_left   = outr.jl;
  assign res.handover    = outr.ho;
  assign res.last_result = out_last;

  // The table never holds more particles than it has rows.
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CMAX)
    else $error("particle count beyond table depth");

  // A step never keeps more particles than it has visited.
  a_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_I_RD) |-> (kept <= i))
    else $error("kept count ahead of visit index");

  // A remove copies no more rows than it has read.
  a_copy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CP_RD) |-> (wk <= k))
    else $error("remove copy index ahead of read index");

  // The pair unit answers only while the sequencer waits for it.
  a_pair_done: assert property (@(posedge clk) disable iff (rst)
    pair_rsp.done |-> (state == S_J_WT))
    else $error("pair answer outside pair wait");

  // The end of a step flushes the held result and returns to idle.
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && hold_valid && out_free) |=> (!hold_valid && state == S_IDLE))
    else $error("step end did not flush held result");

endmodule
